>>> hw/rtl/htsf_pkg.sv
// ----------------------------------------------------------------------------
// htsf_pkg
// Shared types, constants and tag tables of the hidden tag stripping filter.
// ----------------------------------------------------------------------------
package htsf_pkg;

    localparam int HOLD_DEPTH = 10;
    localparam int IDX_W      = $clog2(HOLD_DEPTH);
    localparam int CNT_W      = 4;   // closing-tag progress reaches 10
    localparam int CODE_W     = 16;
    localparam int LIMIT_W    = 24;
    localparam int APB_AW     = 3;
    localparam int APB_DW     = 32;

    localparam logic [LIMIT_W-1:0] MAX_CHARS_RESET = 24'd65535;
    localparam logic               REG_MAX_CHARS   = 1'b0;   // paddr[2]

    localparam logic [CODE_W-1:0] CHAR_LT = 16'h003C;
    localparam logic [CODE_W-1:0] CHAR_NL = 16'h000A;

    localparam logic [1:0] KIND_NONE     = 2'd0;
    localparam logic [1:0] KIND_THINK    = 2'd1;
    localparam logic [1:0] KIND_ANALYSIS = 2'd2;

    localparam logic [CNT_W-1:0] OPEN_LEN_THINK     = 4'd7;
    localparam logic [CNT_W-1:0] OPEN_LEN_ANALYSIS  = 4'd10;
    localparam logic [CNT_W-1:0] CLOSE_LEN_THINK    = 4'd8;
    localparam logic [CNT_W-1:0] CLOSE_LEN_ANALYSIS = 4'd11;

    localparam logic [8*7-1:0]  OPEN_THINK_STR     = "<think>";
    localparam logic [8*10-1:0] OPEN_ANALYSIS_STR  = "<analysis>";
    localparam logic [8*8-1:0]  CLOSE_THINK_STR    = "</think>";
    localparam logic [8*11-1:0] CLOSE_ANALYSIS_STR = "</analysis>";

    typedef enum logic [1:0] {
        ACT_UPDATE,
        ACT_PASS,
        ACT_RELEASE
    } act_t;

    typedef struct packed {
        logic             load;
        logic             commit;
        logic             pass_c;
        logic             pass_held;
        logic [IDX_W-1:0] idx;
        logic             clear_held;
        logic             hold_lt;
        logic             reset_filter;
        logic             flush;
    } cmd_t;

    typedef struct packed {
        act_t             act;
        logic             hiding;
        logic [CNT_W-1:0] held_count;
        logic             eos;
        logic             c_lt;
        logic             pend_valid;
        logic             out_free;
    } status_t;

    // ASCII-only case fold
    function automatic logic [CODE_W-1:0] fold(input logic [CODE_W-1:0] c);
        logic [CODE_W-1:0] r;
        r = c;
        if (c >= 16'h0041 && c <= 16'h005A) begin
            r = c + 16'h0020;
        end
        return r;
    endfunction

    function automatic logic [7:0] open_char(input logic [1:0] kind,
                                             input logic [CNT_W-1:0] idx);
        logic [7:0] r;
        int pos;
        r   = 8'h00;
        pos = int'(idx);
        if (kind == KIND_THINK && idx < OPEN_LEN_THINK) begin
            r = OPEN_THINK_STR[8*(int'(OPEN_LEN_THINK)-1-pos) +: 8];
        end else if (kind == KIND_ANALYSIS && idx < OPEN_LEN_ANALYSIS) begin
            r = OPEN_ANALYSIS_STR[8*(int'(OPEN_LEN_ANALYSIS)-1-pos) +: 8];
        end
        return r;
    endfunction

    function automatic logic [7:0] close_char(input logic [1:0] kind,
                                              input logic [CNT_W-1:0] idx);
        logic [7:0] r;
        int pos;
        r   = 8'h00;
        pos = int'(idx);
        if (kind == KIND_THINK && idx < CLOSE_LEN_THINK) begin
            r = CLOSE_THINK_STR[8*(int'(CLOSE_LEN_THINK)-1-pos) +: 8];
        end else if (kind == KIND_ANALYSIS && idx < CLOSE_LEN_ANALYSIS) begin
            r = CLOSE_ANALYSIS_STR[8*(int'(CLOSE_LEN_ANALYSIS)-1-pos) +: 8];
        end
        return r;
    endfunction

    function automatic logic [CNT_W-1:0] close_len(input logic [1:0] kind);
        logic [CNT_W-1:0] r;
        r = '0;
        if (kind == KIND_THINK) begin
            r = CLOSE_LEN_THINK;
        end else if (kind == KIND_ANALYSIS) begin
            r = CLOSE_LEN_ANALYSIS;
        end
        return r;
    endfunction

endpackage

>>> hw/rtl/hidden_tag_stripping_filter.sv
// ----------------------------------------------------------------------------
// hidden_tag_stripping_filter
// Strips <think>/<analysis> sections from a UTF-16 stream, collapses newline
// runs and truncates with an ellipsis marker after max_chars units.
// ----------------------------------------------------------------------------
// A unit that passes or is absorbed into a tag goes through a decide step and a
// flush step that hands its last result to the output register, overlapping
// with taking the next unit. A failed tag match adds a release step per released
// held unit and a tail step for the unit itself; end_of_stream adds end-of-stream
// and reset steps plus a release step per released unit. The release sequencer
// emits one result per cycle through a single output register, so a stalled m_ready holds it.
// max_chars sits at byte address 0 of the APB port and resets to 65535.
module hidden_tag_stripping_filter (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_valid,
    output logic                            s_ready,
    input  logic [htsf_pkg::CODE_W-1:0]     s_char_code,
    input  logic                            s_end_of_stream,
    output logic                            m_valid,
    input  logic                            m_ready,
    output logic [htsf_pkg::CODE_W-1:0]     m_out_code,
    output logic                            m_is_ellipsis,
    output logic                            m_last_of_run,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [htsf_pkg::APB_AW-1:0]     paddr,
    input  logic [htsf_pkg::APB_DW-1:0]     pwdata,
    output logic [htsf_pkg::APB_DW-1:0]     prdata,
    output logic                            pready
);

    localparam int LW = htsf_pkg::LIMIT_W;

    logic [LW-1:0]     max_chars_reg, max_chars_next;
    htsf_pkg::cmd_t    cmd;
    htsf_pkg::status_t stat;

    assign pready = 1'b1;

    always_comb begin
        max_chars_next = max_chars_reg;
        if (psel && penable && pwrite && paddr[2] == htsf_pkg::REG_MAX_CHARS) begin
            max_chars_next = pwdata[LW-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            max_chars_reg <= htsf_pkg::MAX_CHARS_RESET;
        end else begin
            max_chars_reg <= max_chars_next;
        end
    end

    assign prdata = (paddr[2] == htsf_pkg::REG_MAX_CHARS) ?
                    {(htsf_pkg::APB_DW-LW)'(0), max_chars_reg} : '0;

    htsf_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .stat    (stat),
        .cmd     (cmd)
    );

    htsf_dp u_dp (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cmd             (cmd),
        .stat            (stat),
        .max_chars       (max_chars_reg),
        .s_char_code     (s_char_code),
        .s_end_of_stream (s_end_of_stream),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_out_code      (m_out_code),
        .m_is_ellipsis   (m_is_ellipsis),
        .m_last_of_run   (m_last_of_run)
    );

    // the ellipsis is always the final result of its unit
    a_ellipsis_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_is_ellipsis |-> m_last_of_run && m_out_code == '0)
        else $error("ellipsis marker not last or carries a code");

    // an opening tag completes before the hold buffer fills
    a_hold_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        !stat.hiding |-> stat.held_count <= htsf_pkg::CNT_W'(htsf_pkg::HOLD_DEPTH - 1))
        else $error("held prefix exceeds hold buffer");

    // a new unit never enters while a result of the previous one is stuck
    a_accept_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |-> !(stat.pend_valid && !stat.out_free))
        else $error("unit accepted with a result still pending");

    // a run always closes with a last-marked result before more input
    a_flush_on_load: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !stat.pend_valid)
        else $error("pending result left across a transfer");

endmodule

>>> hw/rtl/htsf_dp.sv
// ----------------------------------------------------------------------------
// htsf_dp
// Datapath: tag match, held prefix, newline collapse, truncation, and the
// pending and output result registers.
// ----------------------------------------------------------------------------
module htsf_dp (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  htsf_pkg::cmd_t                  cmd,
    output htsf_pkg::status_t               stat,
    input  logic [htsf_pkg::LIMIT_W-1:0]    max_chars,
    input  logic [htsf_pkg::CODE_W-1:0]     s_char_code,
    input  logic                            s_end_of_stream,
    output logic                            m_valid,
    input  logic                            m_ready,
    output logic [htsf_pkg::CODE_W-1:0]     m_out_code,
    output logic                            m_is_ellipsis,
    output logic                            m_last_of_run
);

    localparam int CW = htsf_pkg::CODE_W;
    localparam int NW = htsf_pkg::CNT_W;
    localparam int LW = htsf_pkg::LIMIT_W;
    localparam int XW = htsf_pkg::IDX_W;

    // current unit
    logic [CW-1:0] c_reg, c_next;
    logic          eos_reg, eos_next;

    // filter state
    logic [1:0]    kind_reg, kind_next;
    logic [NW-1:0] count_reg, count_next;
    logic [1:0]    cand_reg, cand_next;   // bit0 think, bit1 analysis
    logic [CW-1:0] held_reg [htsf_pkg::HOLD_DEPTH];
    logic [1:0]    nl_run_reg, nl_run_next;
    logic [LW-1:0] emitted_reg, emitted_next;
    logic          stopped_reg, stopped_next;

    // pending result and output register
    logic          pend_valid_reg, pend_valid_next;
    logic [CW-1:0] pend_code_reg, pend_code_next;
    logic          pend_ell_reg, pend_ell_next;
    logic          m_valid_reg, m_valid_next;
    logic [CW-1:0] m_code_reg, m_code_next;
    logic          m_ell_reg, m_ell_next;
    logic          m_last_reg, m_last_next;

    logic          held_we;
    logic [XW-1:0] held_waddr;
    logic [CW-1:0] held_wdata;

    logic [CW-1:0] fc;
    logic          c_lt;
    logic          hiding;
    logic [NW-1:0] clen;
    logic          close_ok;
    logic          fit_think;
    logic          fit_anl;
    logic [NW-1:0] count_inc;

    logic [CW-1:0] unit;
    logic          unit_nl;
    logic          out_free;
    htsf_pkg::act_t act;

    assign fc        = htsf_pkg::fold(c_reg);
    assign c_lt      = (c_reg == htsf_pkg::CHAR_LT);
    assign hiding    = (kind_reg != htsf_pkg::KIND_NONE);
    assign clen      = htsf_pkg::close_len(kind_reg);
    assign count_inc = count_reg + NW'(1);
    assign close_ok  = (count_reg < clen) &&
                       (fc == {8'h00, htsf_pkg::close_char(kind_reg, count_reg)});
    assign fit_think = cand_reg[0] && (count_inc <= htsf_pkg::OPEN_LEN_THINK) &&
                       (fc == {8'h00, htsf_pkg::open_char(htsf_pkg::KIND_THINK,
                                                          count_reg)});
    assign fit_anl   = cand_reg[1] && (count_inc <= htsf_pkg::OPEN_LEN_ANALYSIS) &&
                       (fc == {8'h00, htsf_pkg::open_char(htsf_pkg::KIND_ANALYSIS,
                                                          count_reg)});

    always_comb begin
        if (stopped_reg || hiding) begin
            act = htsf_pkg::ACT_UPDATE;
        end else if (count_reg == '0) begin
            act = c_lt ? htsf_pkg::ACT_UPDATE : htsf_pkg::ACT_PASS;
        end else if (fit_think || fit_anl) begin
            act = htsf_pkg::ACT_UPDATE;
        end else begin
            act = htsf_pkg::ACT_RELEASE;
        end
    end

    assign out_free = !m_valid_reg || m_ready;
    assign unit     = cmd.pass_held ? held_reg[cmd.idx] : c_reg;
    assign unit_nl  = (unit == htsf_pkg::CHAR_NL);

    always_comb begin
        c_next          = c_reg;
        eos_next        = eos_reg;
        kind_next       = kind_reg;
        count_next      = count_reg;
        cand_next       = cand_reg;
        nl_run_next     = nl_run_reg;
        emitted_next    = emitted_reg;
        stopped_next    = stopped_reg;
        pend_valid_next = pend_valid_reg;
        pend_code_next  = pend_code_reg;
        pend_ell_next   = pend_ell_reg;
        m_code_next     = m_code_reg;
        m_ell_next      = m_ell_reg;
        m_last_next     = m_last_reg;
        m_valid_next    = m_valid_reg && !m_ready;
        held_we         = 1'b0;
        held_waddr      = count_reg[XW-1:0];
        held_wdata      = c_reg;

        if (cmd.load) begin
            c_next   = s_char_code;
            eos_next = s_end_of_stream;
        end

        if (cmd.commit && !stopped_reg) begin
            if (hiding) begin
                if (close_ok) begin
                    if (count_inc == clen) begin
                        kind_next  = htsf_pkg::KIND_NONE;
                        count_next = '0;
                    end else begin
                        count_next = count_inc;
                    end
                end else begin
                    count_next = c_lt ? NW'(1) : '0;
                end
            end else if (count_reg == '0) begin
                held_we    = 1'b1;
                held_waddr = '0;
                count_next = NW'(1);
                cand_next  = 2'b11;
            end else if (fit_think && count_inc == htsf_pkg::OPEN_LEN_THINK) begin
                kind_next  = htsf_pkg::KIND_THINK;
                count_next = '0;
            end else if (fit_anl && count_inc == htsf_pkg::OPEN_LEN_ANALYSIS) begin
                kind_next  = htsf_pkg::KIND_ANALYSIS;
                count_next = '0;
            end else begin
                held_we    = 1'b1;
                count_next = count_inc;
                cand_next  = {fit_anl, fit_think};
            end
        end

        if (cmd.hold_lt) begin
            held_we    = 1'b1;
            held_waddr = '0;
            count_next = NW'(1);
            cand_next  = 2'b11;
        end

        if (cmd.clear_held) begin
            count_next = '0;
        end

        // newline collapse, then truncation
        if ((cmd.pass_c || cmd.pass_held) && !stopped_reg &&
            !(unit_nl && nl_run_reg == 2'd2)) begin
            nl_run_next = unit_nl ? nl_run_reg + 2'd1 : 2'd0;
            if (pend_valid_reg) begin
                m_valid_next = 1'b1;
                m_code_next  = pend_code_reg;
                m_ell_next   = pend_ell_reg;
                m_last_next  = 1'b0;
            end
            pend_valid_next = 1'b1;
            if (emitted_reg >= max_chars) begin
                pend_code_next = '0;
                pend_ell_next  = 1'b1;
                stopped_next   = 1'b1;
            end else begin
                pend_code_next = unit;
                pend_ell_next  = 1'b0;
                emitted_next   = emitted_reg + LW'(1);
            end
        end

        if (cmd.reset_filter) begin
            kind_next    = htsf_pkg::KIND_NONE;
            count_next   = '0;
            nl_run_next  = '0;
            emitted_next = '0;
            stopped_next = 1'b0;
        end

        // close the run: the held-back result goes out marked last
        if (cmd.flush && pend_valid_reg) begin
            m_valid_next    = 1'b1;
            m_code_next     = pend_code_reg;
            m_ell_next      = pend_ell_reg;
            m_last_next     = 1'b1;
            pend_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            eos_reg        <= 1'b0;
            kind_reg       <= htsf_pkg::KIND_NONE;
            count_reg      <= '0;
            cand_reg       <= '0;
            nl_run_reg     <= '0;
            emitted_reg    <= '0;
            stopped_reg    <= 1'b0;
            pend_valid_reg <= 1'b0;
            m_valid_reg    <= 1'b0;
        end else begin
            eos_reg        <= eos_next;
            kind_reg       <= kind_next;
            count_reg      <= count_next;
            cand_reg       <= cand_next;
            nl_run_reg     <= nl_run_next;
            emitted_reg    <= emitted_next;
            stopped_reg    <= stopped_next;
            pend_valid_reg <= pend_valid_next;
            m_valid_reg    <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        c_reg         <= c_next;
        pend_code_reg <= pend_code_next;
        pend_ell_reg  <= pend_ell_next;
        m_code_reg    <= m_code_next;
        m_ell_reg     <= m_ell_next;
        m_last_reg    <= m_last_next;
        if (held_we) begin
            held_reg[held_waddr] <= held_wdata;
        end
    end

    assign stat.act        = act;
    assign stat.hiding     = hiding;
    assign stat.held_count = count_reg;
    assign stat.eos        = eos_reg;
    assign stat.c_lt       = c_lt;
    assign stat.pend_valid = pend_valid_reg;
    assign stat.out_free   = out_free;

    assign m_valid       = m_valid_reg;
    assign m_out_code    = m_code_reg;
    assign m_is_ellipsis = m_ell_reg;
    assign m_last_of_run = m_last_reg;

endmodule

>>> hw/rtl/htsf_ctrl.sv
// ----------------------------------------------------------------------------
// htsf_ctrl
// Controller: steps one unit through decide, release, tail, end-of-stream,
// reset and flush phases, and drives the datapath commands.
// ----------------------------------------------------------------------------
module htsf_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  htsf_pkg::status_t stat,
    output htsf_pkg::cmd_t    cmd
);

    localparam int XW = htsf_pkg::IDX_W;
    localparam int NW = htsf_pkg::CNT_W;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DECIDE,
        ST_REL,
        ST_TAIL,
        ST_EOS,
        ST_RESET,
        ST_FLUSH
    } state_t;

    state_t        state_reg, state_next;
    logic [XW-1:0] idx_reg, idx_next;
    logic          eos_phase_reg, eos_phase_next;
    state_t        after_unit;

    // end of the filter step: end-of-stream handling or straight to flush
    assign after_unit = stat.eos ? ST_EOS : ST_FLUSH;

    always_comb begin
        cmd            = '0;
        cmd.idx        = idx_reg;
        state_next     = state_reg;
        idx_next       = idx_reg;
        eos_phase_next = eos_phase_reg;
        s_ready        = 1'b0;

        unique case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.load   = 1'b1;
                    state_next = ST_DECIDE;
                end
            end
            ST_DECIDE: begin
                unique case (stat.act)
                    htsf_pkg::ACT_UPDATE: begin
                        cmd.commit = 1'b1;
                        state_next = after_unit;
                    end
                    htsf_pkg::ACT_PASS: begin
                        if (stat.out_free) begin
                            cmd.pass_c = 1'b1;
                            state_next = after_unit;
                        end
                    end
                    htsf_pkg::ACT_RELEASE: begin
                        idx_next       = '0;
                        eos_phase_next = 1'b0;
                        state_next     = ST_REL;
                    end
                    default: begin
                        state_next = ST_FLUSH;
                    end
                endcase
            end
            ST_REL: begin
                if (stat.out_free) begin
                    cmd.pass_held = 1'b1;
                    if (NW'(idx_reg) + NW'(1) == stat.held_count) begin
                        cmd.clear_held = 1'b1;
                        state_next     = eos_phase_reg ? ST_RESET : ST_TAIL;
                    end else begin
                        idx_next = idx_reg + XW'(1);
                    end
                end
            end
            ST_TAIL: begin
                if (stat.c_lt) begin
                    cmd.hold_lt = 1'b1;
                    state_next  = after_unit;
                end else if (stat.out_free) begin
                    cmd.pass_c = 1'b1;
                    state_next = after_unit;
                end
            end
            ST_EOS: begin
                if (!stat.hiding && stat.held_count != '0) begin
                    idx_next       = '0;
                    eos_phase_next = 1'b1;
                    state_next     = ST_REL;
                end else begin
                    state_next = ST_RESET;
                end
            end
            ST_RESET: begin
                cmd.reset_filter = 1'b1;
                state_next       = ST_FLUSH;
            end
            ST_FLUSH: begin
                // take the next unit in the same cycle the last result goes out
                if (!stat.pend_valid || stat.out_free) begin
                    cmd.flush = 1'b1;
                    s_ready   = 1'b1;
                    if (s_valid) begin
                        cmd.load   = 1'b1;
                        state_next = ST_DECIDE;
                    end else begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            idx_reg       <= '0;
            eos_phase_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            idx_reg       <= idx_next;
            eos_phase_reg <= eos_phase_next;
        end
    end

endmodule

>>> tb/tag_filter_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tag_filter_checker
// Watches the input, result and APB channels of the hidden tag stripping
// filter. It keeps its own model of tag hiding, newline collapse and
// truncation, and compares every result transfer, field by field, against
// the oldest predicted unit.
// ----------------------------------------------------------------------------
module tag_filter_checker (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_valid,
    input  logic                            s_ready,
    input  logic [htsf_pkg::CODE_W-1:0]     s_char_code,
    input  logic                            s_end_of_stream,
    input  logic                            m_valid,
    input  logic                            m_ready,
    input  logic [htsf_pkg::CODE_W-1:0]     m_out_code,
    input  logic                            m_is_ellipsis,
    input  logic                            m_last_of_run,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [htsf_pkg::APB_AW-1:0]     paddr,
    input  logic [htsf_pkg::APB_DW-1:0]     pwdata,
    input  logic                            pready,
    output int                              mismatches,
    output int                              pending_count,
    output int                              units_seen,
    output int                              results_seen,
    output int                              ellipses_seen,
    output int                              hidden_sections
);

    localparam int CW           = htsf_pkg::CODE_W;
    localparam int LW           = htsf_pkg::LIMIT_W;
    localparam int DEPTH        = htsf_pkg::HOLD_DEPTH;
    localparam int MAX_RESULTS  = 12;
    localparam logic [htsf_pkg::APB_AW-1:0] LIMIT_ADDR = {htsf_pkg::REG_MAX_CHARS, 2'b00};

    typedef struct packed {
        logic [CW-1:0] code;
        logic          ellipsis;
        logic          last;
    } shown_unit_t;

    // filter state
    logic [1:0]    hide_kind;
    logic [CW-1:0] held_code [DEPTH];
    int            held_len;
    int            nl_streak;
    logic [LW-1:0] passed_total;
    logic          truncated;
    logic [LW-1:0] char_limit;

    shown_unit_t step_out[$];
    shown_unit_t expected_units[$];

    function automatic logic [CW-1:0] lower_ascii(input logic [CW-1:0] c);
        return (c >= 16'h0041 && c <= 16'h005A) ? c + 16'h0020 : c;
    endfunction

    function automatic string tag_text(input logic closing, input logic [1:0] kind);
        string t;
        t = "";
        if (kind == htsf_pkg::KIND_THINK) begin
            t = closing ? "</think>" : "<think>";
        end else if (kind == htsf_pkg::KIND_ANALYSIS) begin
            t = closing ? "</analysis>" : "<analysis>";
        end
        return t;
    endfunction

    function automatic void push_result(input logic [CW-1:0] c, input logic ell);
        shown_unit_t r;
        if (step_out.size() >= MAX_RESULTS) return;
        r.code     = c;
        r.ellipsis = ell;
        r.last     = 1'b0;
        step_out.push_back(r);
    endfunction

    // newline collapse, then the truncation limit
    function automatic void emit_unit(input logic [CW-1:0] c);
        if (truncated) return;
        if (c == htsf_pkg::CHAR_NL) begin
            if (nl_streak >= 2) return;
            nl_streak++;
        end else begin
            nl_streak = 0;
        end
        if (passed_total >= char_limit) begin
            push_result('0, 1'b1);
            truncated = 1'b1;
            return;
        end
        push_result(c, 1'b0);
        passed_total = passed_total + 1'b1;
    endfunction

    function automatic void release_held();
        int i;
        for (i = 0; i < held_len && i < DEPTH; i++) begin
            emit_unit(held_code[i]);
        end
        held_len = 0;
    endfunction

    function automatic logic open_fits(input logic [1:0] kind, input int n,
                                       input logic [CW-1:0] c);
        string t;
        int i;
        t = tag_text(1'b0, kind);
        if (n + 1 > t.len()) return 1'b0;
        for (i = 0; i < n && i < DEPTH; i++) begin
            if (lower_ascii(held_code[i]) != {8'h00, t[i]}) return 1'b0;
        end
        return lower_ascii(c) == {8'h00, t[n]};
    endfunction

    function automatic void filter_char(input logic [CW-1:0] c);
        int n;
        string t;
        logic [1:0] k;
        n = held_len;
        if (hide_kind != htsf_pkg::KIND_NONE) begin
            // drop everything, track progress on the closing tag
            t = tag_text(1'b1, hide_kind);
            if (n < t.len() && lower_ascii(c) == {8'h00, t[n]}) begin
                n++;
                if (n == t.len()) begin
                    hide_kind = htsf_pkg::KIND_NONE;
                    n = 0;
                end
            end else begin
                n = (c == htsf_pkg::CHAR_LT) ? 1 : 0;
            end
            held_len = n;
            return;
        end
        if (n == 0) begin
            if (c == htsf_pkg::CHAR_LT) begin
                held_code[0] = c;
                held_len = 1;
            end else begin
                emit_unit(c);
            end
            return;
        end
        for (k = htsf_pkg::KIND_THINK; k <= htsf_pkg::KIND_ANALYSIS; k++) begin
            if (open_fits(k, n, c)) begin
                t = tag_text(1'b0, k);
                if (n + 1 == t.len()) begin
                    hide_kind = k;
                    held_len = 0;
                    hidden_sections++;
                    return;
                end
                if (n < DEPTH) begin
                    held_code[n] = c;
                    held_len = n + 1;
                    return;
                end
            end
        end
        release_held();
        if (c == htsf_pkg::CHAR_LT) begin
            held_code[0] = c;
            held_len = 1;
        end else begin
            emit_unit(c);
        end
    endfunction

    function automatic void clear_stream();
        int i;
        hide_kind    = htsf_pkg::KIND_NONE;
        held_len     = 0;
        nl_streak    = 0;
        passed_total = '0;
        truncated    = 1'b0;
        for (i = 0; i < DEPTH; i++) begin
            held_code[i] = '0;
        end
    endfunction

    function automatic void predict_unit(input logic [CW-1:0] c, input logic eos);
        shown_unit_t r;
        step_out.delete();
        if (!truncated) filter_char(c);
        if (eos) begin
            if (hide_kind == htsf_pkg::KIND_NONE) release_held();
            clear_stream();
        end
        if (step_out.size() > 0) begin
            r = step_out.pop_back();
            r.last = 1'b1;
            step_out.push_back(r);
        end
        foreach (step_out[i]) begin
            expected_units.push_back(step_out[i]);
        end
    endfunction

    task automatic report_mismatch(input string what);
        mismatches++;
        $display("MISMATCH at %0t ns: %s", $time, what);
    endtask

    initial begin
        mismatches      = 0;
        pending_count   = 0;
        units_seen      = 0;
        results_seen    = 0;
        ellipses_seen   = 0;
        hidden_sections = 0;
        char_limit      = htsf_pkg::MAX_CHARS_RESET;
        clear_stream();
    end

    always @(posedge aclk) begin
        shown_unit_t want;
        if (!aresetn) begin
            expected_units.delete();
            char_limit = htsf_pkg::MAX_CHARS_RESET;
            clear_stream();
        end else begin
            if (psel && penable && pwrite && pready && paddr == LIMIT_ADDR) begin
                char_limit = pwdata[LW-1:0];
            end
            if (s_valid && s_ready) begin
                units_seen++;
                predict_unit(s_char_code, s_end_of_stream);
            end
            if (m_valid && m_ready) begin
                results_seen++;
                if (m_is_ellipsis === 1'b1) ellipses_seen++;
                if (expected_units.size() == 0) begin
                    report_mismatch($sformatf("unexpected result code=%h ellipsis=%b",
                                              m_out_code, m_is_ellipsis));
                end else begin
                    want = expected_units.pop_front();
                    if (m_out_code !== want.code) begin
                        report_mismatch($sformatf("out_code %h, predicted %h",
                                                  m_out_code, want.code));
                    end
                    if (m_is_ellipsis !== want.ellipsis) begin
                        report_mismatch($sformatf("is_ellipsis %b, predicted %b (code %h)",
                                                  m_is_ellipsis, want.ellipsis, want.code));
                    end
                    if (m_last_of_run !== want.last) begin
                        report_mismatch($sformatf("last_of_run %b, predicted %b (code %h)",
                                                  m_last_of_run, want.last, want.code));
                    end
                end
            end
        end
        pending_count = expected_units.size();
    end

endmodule

>>> tb/hidden_tag_stripping_filter_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hidden_tag_stripping_filter_test
// Drives text streams with hidden sections, broken and partial tags, newline
// runs and raw code units through the filter under several truncation limits
// and flow-control mixes; the checker beside the block judges every result.
// ----------------------------------------------------------------------------
module hidden_tag_stripping_filter_test;

    localparam int CW = htsf_pkg::CODE_W;
    localparam int LW = htsf_pkg::LIMIT_W;
    localparam int AW = htsf_pkg::APB_AW;
    localparam int DW = htsf_pkg::APB_DW;

    // release of a full hold plus end-of-stream handling, with margin
    localparam int SETTLE_CYCLES = 32;
    localparam logic [AW-1:0] LIMIT_ADDR = {htsf_pkg::REG_MAX_CHARS, 2'b00};

    logic            aclk;
    logic            aresetn;
    logic            s_valid;
    logic            s_ready;
    logic [CW-1:0]   s_char_code;
    logic            s_end_of_stream;
    logic            m_valid;
    logic            m_ready;
    logic [CW-1:0]   m_out_code;
    logic            m_is_ellipsis;
    logic            m_last_of_run;
    logic            psel;
    logic            penable;
    logic            pwrite;
    logic [AW-1:0]   paddr;
    logic [DW-1:0]   pwdata;
    logic [DW-1:0]   prdata;
    logic            pready;

    int mismatches;
    int pending_count;
    int units_seen;
    int results_seen;
    int ellipses_seen;
    int hidden_sections;

    int idle_pct;
    int stall_pct;
    int units_sent;
    int streams_sent;
    logic [CW-1:0] text_q[$];

    hidden_tag_stripping_filter dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_char_code     (s_char_code),
        .s_end_of_stream (s_end_of_stream),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_out_code      (m_out_code),
        .m_is_ellipsis   (m_is_ellipsis),
        .m_last_of_run   (m_last_of_run),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready)
    );

    tag_filter_checker u_checker (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_char_code     (s_char_code),
        .s_end_of_stream (s_end_of_stream),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_out_code      (m_out_code),
        .m_is_ellipsis   (m_is_ellipsis),
        .m_last_of_run   (m_last_of_run),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .pready          (pready),
        .mismatches      (mismatches),
        .pending_count   (pending_count),
        .units_seen      (units_seen),
        .results_seen    (results_seen),
        .ellipses_seen   (ellipses_seen),
        .hidden_sections (hidden_sections)
    );

    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    initial begin
        #5_000_000;
        $display("Timeout with %0d results still outstanding", pending_count);
        $display("DONE: errors detected");
        $finish;
    end

    // receiver back-pressure
    initial begin
        m_ready = 1'b1;
        forever begin
            @(negedge aclk);
            m_ready <= ($urandom_range(99) >= stall_pct);
        end
    end

    // append ASCII text, letters optionally in random case
    task automatic add_text(input string s, input logic mixed_case);
        int i;
        logic [7:0] ch;
        for (i = 0; i < s.len(); i++) begin
            ch = s[i];
            if (mixed_case && ch >= "a" && ch <= "z" && $urandom_range(1) != 0) begin
                ch = ch - 8'h20;
            end
            text_q.push_back({8'h00, ch});
        end
    endtask

    task automatic add_piece();
        string word;
        string tag;
        int n;
        int i;
        word = ($urandom_range(1) != 0) ? "analysis" : "think";
        case ($urandom_range(0, 9))
            0, 1, 2: begin
                n = $urandom_range(1, 6);
                for (i = 0; i < n; i++) text_q.push_back(CW'($urandom_range(32, 126)));
            end
            3: begin
                n = $urandom_range(1, 5);
                repeat (n) text_q.push_back(htsf_pkg::CHAR_NL);
            end
            4: begin
                // well-formed hidden section with noisy content
                add_text({"<", word, ">"}, 1'b1);
                n = $urandom_range(0, 6);
                for (i = 0; i < n; i++) begin
                    case ($urandom_range(0, 5))
                        0: text_q.push_back(CW'($urandom_range(32, 126)));
                        1: text_q.push_back(htsf_pkg::CHAR_LT);
                        2: begin
                            tag = {"</", word, ">"};
                            add_text(tag.substr(0, $urandom_range(0, tag.len() - 2)), 1'b1);
                        end
                        3: text_q.push_back(htsf_pkg::CHAR_NL);
                        4: text_q.push_back(CW'($urandom_range(0, 65535)));
                        default: add_text((word == "think") ? "</analysis>" : "</think>", 1'b1);
                    endcase
                end
                if ($urandom_range(9) != 0) add_text({"</", word, ">"}, 1'b1);
            end
            5: begin
                // partial opening tag, maybe broken by the next unit
                tag = {"<", word, ">"};
                add_text(tag.substr(0, $urandom_range(0, tag.len() - 2)), 1'b1);
                if ($urandom_range(1) != 0) text_q.push_back(CW'($urandom_range(32, 126)));
            end
            6: add_text({"</", word, ">"}, 1'b1);
            7: begin
                n = $urandom_range(1, 3);
                for (i = 0; i < n; i++) text_q.push_back(CW'($urandom_range(0, 65535)));
            end
            8: begin
                // non-ASCII look-alike in place of a tag letter
                tag = {"<", word, ">"};
                n = $urandom_range(1, tag.len() - 2);
                add_text(tag.substr(0, n - 1), 1'b0);
                text_q.push_back({8'h01, tag[n]});
            end
            default: begin
                repeat ($urandom_range(1, 3)) text_q.push_back(htsf_pkg::CHAR_LT);
                add_text({"<", word, ">"}, 1'b1);
            end
        endcase
    endtask

    // caller stands at a falling edge; returns at the falling edge after the transfer
    task automatic send_unit(input logic [CW-1:0] c, input logic eos);
        while ($urandom_range(99) < idle_pct) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid         <= 1'b1;
        s_char_code     <= c;
        s_end_of_stream <= eos;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        @(negedge aclk);
    endtask

    task automatic send_stream();
        int i;
        for (i = 0; i < text_q.size(); i++) begin
            send_unit(text_q[i], i == text_q.size() - 1);
        end
        units_sent += text_q.size();
        streams_sent++;
        text_q.delete();
    endtask

    // hold the sender until the block has delivered everything predicted
    task automatic wait_drained(input int extra);
        s_valid <= 1'b0;
        while (pending_count != 0) @(negedge aclk);
        repeat (extra) @(negedge aclk);
    endtask

    task automatic write_limit(input logic [LW-1:0] value);
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        penable <= 1'b0;
        paddr   <= LIMIT_ADDR;
        pwdata  <= {{(DW - LW){1'b0}}, value};
        @(negedge aclk);
        penable <= 1'b1;
        @(negedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic run_phase(input logic [LW-1:0] limit, input int idle, input int stall,
                             input int units, input logic pause_midway);
        int start;
        wait_drained(SETTLE_CYCLES);
        write_limit(limit);
        idle_pct  = idle;
        stall_pct = stall;
        start     = units_sent;
        while (units_sent - start < units) begin
            if (pause_midway && units_sent - start >= units / 2) begin
                wait_drained(0);
                pause_midway = 1'b0;
            end
            repeat ($urandom_range(1, 6)) add_piece();
            send_stream();
        end
    endtask

    initial begin
        aresetn         = 1'b0;
        s_valid         = 1'b0;
        s_char_code     = '0;
        s_end_of_stream = 1'b0;
        psel            = 1'b0;
        penable         = 1'b0;
        pwrite          = 1'b0;
        paddr           = '0;
        pwdata          = '0;
        idle_pct        = 0;
        stall_pct       = 0;
        units_sent      = 0;
        streams_sent    = 0;
        repeat (3) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // directed: field extremes, newline collapse, a hidden section in mixed
        // case, and a partial tag released at end of stream
        text_q.push_back(16'h0000);
        text_q.push_back(16'hFFFF);
        repeat (4) text_q.push_back(htsf_pkg::CHAR_NL);
        add_text("<Think>q</THINK><a", 1'b0);
        send_stream();

        run_phase(24'hFFFFFF, 0, 0, 100, 1'b0);
        run_phase(24'd1, 50, 0, 90, 1'b0);
        run_phase(LW'($urandom_range(3, 40)), 0, 50, 110, 1'b1);
        run_phase(htsf_pkg::MAX_CHARS_RESET, 16, 16, 110, 1'b0);
        run_phase(LW'($urandom_range(1, 12)), 0, 0, 100, 1'b0);
        wait_drained(SETTLE_CYCLES);

        $display("Sent %0d units in %0d streams under five limit and flow-control mixes",
                 units_seen, streams_sent);
        $display("Checked %0d results: %0d ellipsis markers, %0d hidden sections entered",
                 results_seen, ellipses_seen, hidden_sections);
        if (mismatches == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
